### rtl/gops_pkg.sv
// ----------------------------------------------------------------------------
// gops_pkg
// Shared types and constants of the glyph outline to path segment core.
// ----------------------------------------------------------------------------
package gops_pkg;

   // Segment buffer geometry
   localparam int MAX_SEG_POINTS = 4;
   localparam int SEG_IDX_W      = $clog2(MAX_SEG_POINTS);
   localparam int SEG_CNT_W      = $clog2(MAX_SEG_POINTS + 1);

   // Fewest points a curve segment holds once padded at contour end
   localparam int NEED_QUAD  = 2;
   localparam int NEED_CUBIC = 3;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int COORD_W = 32;

   typedef enum logic [2:0] {
      KIND_CLOSE = 3'd0,
      KIND_MOVE  = 3'd1,
      KIND_LINE  = 3'd2,
      KIND_QUAD  = 3'd3,
      KIND_CUBIC = 3'd4
   } kind_type;

   // Class of one outline point as seen by the front
   typedef enum logic [1:0] {
      OP_MOVE = 2'd0,
      OP_ON   = 2'd1,
      OP_OFF  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic                      cubic;
      logic                      cend;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } cmd_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

endpackage

### rtl/gops_front.sv
// ----------------------------------------------------------------------------
// gops_front
// Accepts outline points, tracks contour start and classifies each point.
// ----------------------------------------------------------------------------
module gops_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [gops_pkg::COORD_W-1:0] req_x,
   input  logic signed [gops_pkg::COORD_W-1:0] req_y,
   input  logic                             req_on_curve,
   input  logic                             req_cubic_control,
   input  logic                             req_contour_end,
   output logic                             cmd_valid,
   input  logic                             cmd_ready,
   output gops_pkg::cmd_type                cmd
);
   import gops_pkg::*;

   logic started_ff;
   logic started_in;
   logic accept;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;

   // First point of a contour is a move-to whatever its tags say
   always_comb begin
      cmd.x     = req_x;
      cmd.y     = req_y;
      cmd.cubic = req_cubic_control;
      cmd.cend  = req_contour_end;
      if (!started_ff) begin
         cmd.op = OP_MOVE;
      end else if (req_on_curve) begin
         cmd.op = OP_ON;
      end else begin
         cmd.op = OP_OFF;
      end
   end

   always_comb begin
      started_in = started_ff;
      if (accept) begin
         started_in = !req_contour_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
      end
   end

endmodule

### rtl/gops_queue.sv
// ----------------------------------------------------------------------------
// gops_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module gops_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  gops_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output gops_pkg::cmd_type pop_cmd
);
   import gops_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   push;
   logic                   pop;

   assign push_ready = cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### rtl/gops_back.sv
// ----------------------------------------------------------------------------
// gops_back
// Segment buffer and result sequencer: executes one command at a time and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module gops_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   output logic                             q_pop,
   input  gops_pkg::cmd_type                q_cmd,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_seg_kind,
   output logic signed [gops_pkg::COORD_W-1:0] rsp_pt_x,
   output logic signed [gops_pkg::COORD_W-1:0] rsp_pt_y,
   output logic                             rsp_has_point,
   output logic                             rsp_segment_end,
   output logic                             rsp_run_end,
   output logic                             rsp_overflow
);
   import gops_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_BUF   = 4'b0010,
      ST_PT    = 4'b0100,
      ST_CLOSE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   kind_type             kind_ff, kind_in;
   kind_type             pend_ff, pend_in;
   logic [SEG_CNT_W-1:0] seg_cnt_ff, seg_cnt_in;
   logic                 seg_ovf_ff, seg_ovf_in;
   point_type            first_ff, first_in;
   logic [SEG_CNT_W-1:0] idx_ff, idx_in;
   logic [SEG_CNT_W-1:0] total_ff, total_in;
   point_type            buf_ff [MAX_SEG_POINTS];

   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff;
   point_type            rsp_pt_ff;
   logic                 rsp_has_ff, rsp_send_ff, rsp_run_ff, rsp_ovf_ff;

   logic                 out_free;
   logic                 off_store;
   logic [SEG_CNT_W-1:0] cnt_after;
   logic [SEG_CNT_W-1:0] need;
   kind_type             pend_new;
   point_type            buf_pt;
   logic                 buf_last;
   logic                 load;
   kind_type             o_kind;
   point_type            o_pt;
   logic                 o_has, o_send, o_run, o_ovf;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   // Keep one slot free for the end point
   assign off_store = seg_cnt_ff < SEG_CNT_W'(MAX_SEG_POINTS - 1);
   assign cnt_after = off_store ? seg_cnt_ff + 1'b1 : seg_cnt_ff;
   assign need      = q_cmd.cubic ? SEG_CNT_W'(NEED_CUBIC) : SEG_CNT_W'(NEED_QUAD);
   assign pend_new  = q_cmd.cubic ? KIND_CUBIC : KIND_QUAD;
   // Slots past the stored count pad with the contour's first point
   assign buf_pt    = (idx_ff < seg_cnt_ff) ? buf_ff[idx_ff[SEG_IDX_W-1:0]] : first_ff;
   assign buf_last  = idx_ff == total_ff - 1'b1;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      kind_in    = kind_ff;
      pend_in    = pend_ff;
      seg_cnt_in = seg_cnt_ff;
      seg_ovf_in = seg_ovf_ff;
      first_in   = first_ff;
      idx_in     = idx_ff;
      total_in   = total_ff;
      load       = 1'b0;
      o_kind     = KIND_CLOSE;
      o_pt       = '0;
      o_has      = 1'b0;
      o_send     = 1'b0;
      o_run      = 1'b0;
      o_ovf      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in = q_cmd;
               idx_in = '0;
               case (q_cmd.op)
                  OP_MOVE: begin
                     first_in.x = q_cmd.x;
                     first_in.y = q_cmd.y;
                     kind_in    = KIND_MOVE;
                     pend_in    = KIND_CLOSE;
                     seg_cnt_in = '0;
                     seg_ovf_in = 1'b0;
                     state_in   = ST_PT;
                  end
                  OP_ON: begin
                     kind_in  = (pend_ff == KIND_CLOSE) ? KIND_LINE : pend_ff;
                     total_in = seg_cnt_ff;
                     state_in = (seg_cnt_ff != '0) ? ST_BUF : ST_PT;
                  end
                  OP_OFF: begin
                     pend_in = pend_new;
                     if (off_store) begin
                        seg_cnt_in = cnt_after;
                     end else begin
                        seg_ovf_in = 1'b1;
                     end
                     if (q_cmd.cend) begin
                        kind_in  = pend_new;
                        total_in = (cnt_after < need) ? need : cnt_after;
                        state_in = ST_BUF;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_BUF: begin
            if (out_free) begin
               load   = 1'b1;
               o_kind = kind_ff;
               o_pt   = buf_pt;
               o_has  = 1'b1;
               o_send = buf_last && (cmd_ff.op != OP_ON);
               o_ovf  = seg_ovf_ff;
               idx_in = idx_ff + 1'b1;
               if (buf_last) begin
                  state_in = (cmd_ff.op == OP_ON) ? ST_PT : ST_CLOSE;
               end
            end
         end
         ST_PT: begin
            if (out_free) begin
               load       = 1'b1;
               o_kind     = kind_ff;
               o_pt.x     = cmd_ff.x;
               o_pt.y     = cmd_ff.y;
               o_has      = 1'b1;
               o_send     = 1'b1;
               o_run      = !cmd_ff.cend;
               o_ovf      = seg_ovf_ff;
               pend_in    = KIND_CLOSE;
               seg_cnt_in = '0;
               seg_ovf_in = 1'b0;
               state_in   = cmd_ff.cend ? ST_CLOSE : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               load       = 1'b1;
               o_kind     = KIND_CLOSE;
               o_send     = 1'b1;
               o_run      = 1'b1;
               pend_in    = KIND_CLOSE;
               seg_cnt_in = '0;
               seg_ovf_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Segment buffer: store an off-curve point while room remains
   always_ff @(posedge clock) begin
      if (q_pop && (q_cmd.op == OP_OFF) && off_store) begin
         buf_ff[seg_cnt_ff[SEG_IDX_W-1:0]] <= point_type'({q_cmd.x, q_cmd.y});
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      kind_ff  <= kind_in;
      first_ff <= first_in;
      idx_ff   <= idx_in;
      total_ff <= total_in;
      if (load) begin
         rsp_kind_ff <= o_kind;
         rsp_pt_ff   <= o_pt;
         rsp_has_ff  <= o_has;
         rsp_send_ff <= o_send;
         rsp_run_ff  <= o_run;
         rsp_ovf_ff  <= o_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= KIND_CLOSE;
         seg_cnt_ff   <= '0;
         seg_ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         seg_cnt_ff   <= seg_cnt_in;
         seg_ovf_ff   <= seg_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seg_kind    = rsp_kind_ff;
   assign rsp_pt_x        = rsp_pt_ff.x;
   assign rsp_pt_y        = rsp_pt_ff.y;
   assign rsp_has_point   = rsp_has_ff;
   assign rsp_segment_end = rsp_send_ff;
   assign rsp_run_end     = rsp_run_ff;
   assign rsp_overflow    = rsp_ovf_ff;

`ifndef ASSERT_OFF
   a_cnt_room: assert property (@(posedge clock) disable iff (reset)
      seg_cnt_ff <= SEG_CNT_W'(MAX_SEG_POINTS - 1))
      else $error("segment buffer holds no free slot for the end point");

   a_idle_seg_empty: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == KIND_CLOSE) |-> (seg_cnt_ff == '0) && !seg_ovf_ff)
      else $error("buffered points without a pending curve kind");

   a_buf_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUF) |-> (idx_ff < total_ff))
      else $error("flush index ran past the segment length");
`endif

endmodule

### rtl/glyph_outline_to_path_segments_core.sv
// ----------------------------------------------------------------------------
// glyph_outline_to_path_segments_core
// Turns a stream of glyph outline points into move/line/quad/cubic/close
// path segment items.
// ----------------------------------------------------------------------------
// Each accepted point becomes a command in a two-entry queue; the back end
// pops one command at a time and then sends its result items one by one.
// An off-curve point in mid-contour therefore yields no result, a move-to
// yields one, and a segment flush sends its buffered and padded points
// (a close marker adds one more item).
// That single result sequencer in the back end sets the sustained rate; the
// queue lets the input side keep taking points while a burst drains. Results
// leave through an output register, so a stalled consumer holds the last
// item and the back end waits without losing state. The segment buffer holds
// MAX_SEG_POINTS points; control points beyond the last free slot but one are
// dropped and every result of that segment carries the overflow flag.
// ----------------------------------------------------------------------------
module glyph_outline_to_path_segments_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [gops_pkg::COORD_W-1:0] req_x,
   input  logic signed [gops_pkg::COORD_W-1:0] req_y,
   input  logic                             req_on_curve,
   input  logic                             req_cubic_control,
   input  logic                             req_contour_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_seg_kind,
   output logic signed [gops_pkg::COORD_W-1:0] rsp_pt_x,
   output logic signed [gops_pkg::COORD_W-1:0] rsp_pt_y,
   output logic                             rsp_has_point,
   output logic                             rsp_segment_end,
   output logic                             rsp_run_end,
   output logic                             rsp_overflow
);
   import gops_pkg::*;

   // Front to queue
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // Queue to back
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   // Classify points: move-to at contour start, else on- or off-curve
   gops_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_x             (req_x),
      .req_y             (req_y),
      .req_on_curve      (req_on_curve),
      .req_cubic_control (req_cubic_control),
      .req_contour_end   (req_contour_end),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd)
   );

   // Hold commands while the back end drains a burst
   gops_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_ready (cmd_ready),
      .push_cmd   (cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_cmd    (q_cmd)
   );

   // Buffer segment points and sequence result items
   gops_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_cmd           (q_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_seg_kind    (rsp_seg_kind),
      .rsp_pt_x        (rsp_pt_x),
      .rsp_pt_y        (rsp_pt_y),
      .rsp_has_point   (rsp_has_point),
      .rsp_segment_end (rsp_segment_end),
      .rsp_run_end     (rsp_run_end),
      .rsp_overflow    (rsp_overflow)
   );

endmodule
